[src/ntew_pkg.sv]
// Shared types, constants and the control-store program for the number speller.
// Depends on nothing; every other file in src imports it.
package ntew_pkg;

  localparam int VALUE_BITS = 64;
  localparam int GROUPS     = 7;
  localparam int BCD_DIGITS = 3 * GROUPS;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int G_W        = $clog2(GROUPS);
  localparam int WORD_W     = 6;
  localparam int PC_W       = 4;

  localparam logic [WORD_W-1:0] CODE_NONE       = 6'd0;
  localparam logic [WORD_W-1:0] CODE_TEN        = 6'd10;
  localparam logic [WORD_W-1:0] CODE_TENS_BASE  = 6'd18;
  localparam logic [WORD_W-1:0] CODE_HUNDRED    = 6'd28;
  localparam logic [WORD_W-1:0] CODE_SCALE_BASE = 6'd28;

  // program addresses
  localparam logic [PC_W-1:0] STEP_LOAD   = 4'd0;
  localparam logic [PC_W-1:0] STEP_HUND   = 4'd1;
  localparam logic [PC_W-1:0] STEP_HWORD  = 4'd2;
  localparam logic [PC_W-1:0] STEP_TEEN   = 4'd3;
  localparam logic [PC_W-1:0] STEP_TENS   = 4'd4;
  localparam logic [PC_W-1:0] STEP_UNIT   = 4'd5;
  localparam logic [PC_W-1:0] STEP_SCALE  = 4'd6;
  localparam logic [PC_W-1:0] STEP_FINISH = 4'd7;
  localparam logic [PC_W-1:0] STEP_NEXT   = 4'd8;

  typedef enum logic [2:0] {
    COND_ALWAYS   = 3'd0,
    COND_GRP_ZERO = 3'd1,
    COND_H_NZ     = 3'd2,
    COND_TEEN     = 3'd3,
    COND_T_NZ     = 3'd4,
    COND_U_NZ     = 3'd5,
    COND_G_NZ     = 3'd6,
    COND_G_ZERO   = 3'd7
  } cond_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_EMIT   = 2'd1,
    ACT_DEC_G  = 2'd2,
    ACT_FINISH = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    SRC_HDIGIT  = 3'd0,
    SRC_HUNDRED = 3'd1,
    SRC_TEEN    = 3'd2,
    SRC_TENS    = 3'd3,
    SRC_UNIT    = 3'd4,
    SRC_SCALE   = 3'd5
  } src_t;

  typedef struct packed {
    cond_t            cond;
    act_t             act;
    src_t             src;
    logic             jump;
    logic [PC_W-1:0]  target;
  } ctl_word_t;

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] code;
    logic              last;
  } push_t;

  // One control word per step. A step whose condition fails just advances.
  function automatic ctl_word_t ntew_rom(input logic [PC_W-1:0] pc);
    ctl_word_t cw;
    cw = '{COND_ALWAYS, ACT_NONE, SRC_HDIGIT, 1'b0, STEP_LOAD};
    case (pc)
      STEP_LOAD:   cw = '{COND_GRP_ZERO, ACT_NONE,   SRC_HDIGIT,  1'b1, STEP_FINISH};
      STEP_HUND:   cw = '{COND_H_NZ,     ACT_EMIT,   SRC_HDIGIT,  1'b0, STEP_LOAD};
      STEP_HWORD:  cw = '{COND_H_NZ,     ACT_EMIT,   SRC_HUNDRED, 1'b0, STEP_LOAD};
      STEP_TEEN:   cw = '{COND_TEEN,     ACT_EMIT,   SRC_TEEN,    1'b1, STEP_SCALE};
      STEP_TENS:   cw = '{COND_T_NZ,     ACT_EMIT,   SRC_TENS,    1'b0, STEP_LOAD};
      STEP_UNIT:   cw = '{COND_U_NZ,     ACT_EMIT,   SRC_UNIT,    1'b0, STEP_LOAD};
      STEP_SCALE:  cw = '{COND_G_NZ,     ACT_EMIT,   SRC_SCALE,   1'b0, STEP_LOAD};
      STEP_FINISH: cw = '{COND_G_ZERO,   ACT_FINISH, SRC_HDIGIT,  1'b0, STEP_LOAD};
      STEP_NEXT:   cw = '{COND_ALWAYS,   ACT_DEC_G,  SRC_HDIGIT,  1'b1, STEP_LOAD};
      default:     cw = '{COND_ALWAYS,   ACT_NONE,   SRC_HDIGIT,  1'b1, STEP_LOAD};
    endcase
    return cw;
  endfunction

endpackage

[src/ntew_bcd.sv]
// Shift-and-add-3 binary to BCD converter, one input bit per cycle.
// Depends on ntew_pkg.
module ntew_bcd
  import ntew_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  done,
  output logic [BCD_W-1:0]      bcd
);

  logic [VALUE_BITS-1:0] sh_r, sh_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt, adj;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  run_r, run_nxt;
  logic                  done_r, done_nxt;

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3 : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    sh_nxt   = sh_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      sh_nxt  = value;
      bcd_nxt = '0;
      cnt_nxt = CNT_W'(VALUE_BITS);
      run_nxt = 1'b1;
    end else if (run_r) begin
      // shift the next binary bit into the adjusted digits
      bcd_nxt = {adj[BCD_W-2:0], sh_r[VALUE_BITS-1]};
      sh_nxt  = {sh_r[VALUE_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

[src/ntew_seq.sv]
// Microcoded word sequencer: walks the three-digit groups top down and
// emits word codes through a one-word holding stage. Depends on ntew_pkg.
module ntew_seq
  import ntew_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [BCD_W-1:0] bcd,
  input  logic             out_free,
  output push_t            push,
  output logic             done
);

  logic              run_r, run_nxt;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic [G_W-1:0]    g_r, g_nxt;
  logic [BCD_W-1:0]  dig_r, dig_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [WORD_W-1:0] pend_code_r, pend_code_nxt;

  ctl_word_t         cw;
  logic [3:0]        h, t, u;
  logic              cond_ok, blocked;
  logic [WORD_W-1:0] word;

  assign cw = ntew_rom(pc_r);
  assign h  = dig_r[BCD_W-1  -: 4];
  assign t  = dig_r[BCD_W-5  -: 4];
  assign u  = dig_r[BCD_W-9  -: 4];

  always_comb begin
    case (cw.cond)
      COND_ALWAYS:   cond_ok = 1'b1;
      COND_GRP_ZERO: cond_ok = (h == 4'd0) && (t == 4'd0) && (u == 4'd0);
      COND_H_NZ:     cond_ok = (h != 4'd0);
      COND_TEEN:     cond_ok = (t == 4'd1) && (u != 4'd0);
      COND_T_NZ:     cond_ok = (t != 4'd0);
      COND_U_NZ:     cond_ok = (u != 4'd0);
      COND_G_NZ:     cond_ok = (g_r != '0);
      COND_G_ZERO:   cond_ok = (g_r == '0);
      default:       cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    case (cw.src)
      SRC_HDIGIT:  word = {2'b00, h};
      SRC_HUNDRED: word = CODE_HUNDRED;
      SRC_TEEN:    word = CODE_TEN + {2'b00, u};
      SRC_TENS:    word = (t == 4'd1) ? CODE_TEN : CODE_TENS_BASE + {2'b00, t};
      SRC_UNIT:    word = {2'b00, u};
      SRC_SCALE:   word = CODE_SCALE_BASE + WORD_W'(g_r);
      default:     word = CODE_NONE;
    endcase
  end

  // hold the step while the output register cannot take the released word
  assign blocked = run_r && cond_ok && !out_free &&
                   ((cw.act == ACT_EMIT && pend_valid_r) || cw.act == ACT_FINISH);

  always_comb begin
    push.valid = run_r && cond_ok && !blocked &&
                 ((cw.act == ACT_EMIT && pend_valid_r) || cw.act == ACT_FINISH);
    push.code  = pend_valid_r ? pend_code_r : CODE_NONE;
    push.last  = (cw.act == ACT_FINISH);
  end

  assign done = run_r && cond_ok && !blocked && (cw.act == ACT_FINISH);

  always_comb begin
    run_nxt        = run_r;
    pc_nxt         = pc_r;
    g_nxt          = g_r;
    dig_nxt        = dig_r;
    pend_valid_nxt = pend_valid_r;
    pend_code_nxt  = pend_code_r;
    if (start) begin
      run_nxt        = 1'b1;
      pc_nxt         = STEP_LOAD;
      g_nxt          = G_W'(GROUPS - 1);
      dig_nxt        = bcd;
      pend_valid_nxt = 1'b0;
    end else if (run_r && !blocked) begin
      if (cond_ok) begin
        case (cw.act)
          ACT_EMIT: begin
            pend_valid_nxt = 1'b1;
            pend_code_nxt  = word;
          end
          ACT_DEC_G: begin
            g_nxt   = g_r - G_W'(1);
            dig_nxt = {dig_r[BCD_W-13:0], 12'd0};
          end
          ACT_FINISH: begin
            run_nxt        = 1'b0;
            pend_valid_nxt = 1'b0;
          end
          default: ;
        endcase
      end
      pc_nxt = (cond_ok && cw.jump) ? cw.target : pc_r + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      pc_r         <= STEP_LOAD;
      g_r          <= '0;
    end else begin
      run_r        <= run_nxt;
      pend_valid_r <= pend_valid_nxt;
      pc_r         <= pc_nxt;
      g_r          <= g_nxt;
    end
    dig_r       <= dig_nxt;
    pend_code_r <= pend_code_nxt;
  end

endmodule

[src/number_to_english_words.sv]
// Number speller top level: input handshake, converter, sequencer, output register.
// Depends on ntew_pkg, ntew_bcd and ntew_seq.
//
// Usage:
//   A request on the input channel carries one unsigned number (in_value; only
//   its low VALUE_BITS bits count). The block answers with its short-scale
//   English spelling as a run of word-code requests on the output channel,
//   the final one flagged by out_last_word. Zero gives one request, code none.
//   Processing: shift-and-add-3 conversion to decimal, a registered handoff,
//   then the control program steps through seven groups of three digits,
//   nine steps per group at most and eight for the lowest (at most 62
//   steps), holding its step while the output stalls. The binary-to-decimal
//   shifter and the single sequencer set how long each number takes.
//   One number is in flight at a time: in_stall is high from acceptance until
//   the final word has entered the output register. The output register is
//   separate, so a new number can be taken while the final word still waits.
//   Receiver stall: the sequencer holds its step, nothing is dropped.
//   Reset (rst_n low, synchronous) empties the output register and returns
//   the block to idle, ready for a request.
module number_to_english_words
  import ntew_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [63:0]       in_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_word_code,
  output logic              out_last_word
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CONV  = 3'b010,
    ST_SPELL = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic              accept;
  logic              bcd_done;
  logic [BCD_W-1:0]  bcd;
  logic              out_free;
  logic              seq_done;
  push_t             push;

  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_code_r, out_code_nxt;
  logic              out_last_r, out_last_nxt;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Output register frees when empty or when its word is taken this cycle.
  assign out_free = !out_valid_r || !out_stall;

  ntew_bcd u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .value (in_value[VALUE_BITS-1:0]),
    .done  (bcd_done),
    .bcd   (bcd)
  );

  ntew_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (bcd_done),
    .bcd      (bcd),
    .out_free (out_free),
    .push     (push),
    .done     (seq_done)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept)   state_nxt = ST_CONV;
      ST_CONV:  if (bcd_done) state_nxt = ST_SPELL;
      ST_SPELL: if (seq_done) state_nxt = ST_IDLE;
      default:                state_nxt = ST_IDLE;
    endcase
  end

  // Load a released word, otherwise drop the held one once it is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    out_last_nxt  = out_last_r;
    if (push.valid) begin
      out_valid_nxt = 1'b1;
      out_code_nxt  = push.code;
      out_last_nxt  = push.last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_code_r <= out_code_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_word_code = out_code_r;
  assign out_last_word = out_last_r;

endmodule

[tb/tb_top.sv]
// Self-checking bench for number_to_english_words: spell-out predictor, scoreboard
// and random traffic with stalls. Depends on ntew_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_top
  import ntew_pkg::*;
();

  localparam int RESET_CYCLES  = 5;
  localparam int RANDOM_ITEMS  = 255;
  localparam int QUIET_ITEMS   = 40;   // tail of the random part with no idling at all
  localparam int HOLD_AT_ITEM  = 60;   // where the receiver holds off for a long stretch
  localparam int LONG_HOLD     = 400;
  localparam int DRAIN_CYCLES  = 200;
  localparam int NUM_DIRECTED  = 25;

  // Word codes typed into the directed table.
  localparam logic [WORD_W-1:0] W_ONE         = 6'd1;
  localparam logic [WORD_W-1:0] W_NINETEEN    = CODE_TEN + 6'd9;
  localparam logic [WORD_W-1:0] W_TWENTY      = CODE_TENS_BASE + 6'd2;
  localparam logic [WORD_W-1:0] W_THOUSAND    = CODE_SCALE_BASE + 6'd1;
  localparam logic [WORD_W-1:0] W_MILLION     = CODE_SCALE_BASE + 6'd2;
  localparam logic [WORD_W-1:0] W_BILLION     = CODE_SCALE_BASE + 6'd3;
  localparam logic [WORD_W-1:0] W_TRILLION    = CODE_SCALE_BASE + 6'd4;
  localparam logic [WORD_W-1:0] W_QUADRILLION = CODE_SCALE_BASE + 6'd5;
  localparam logic [WORD_W-1:0] W_QUINTILLION = CODE_SCALE_BASE + 6'd6;
  localparam logic [WORD_W-1:0] W_PAD         = CODE_NONE;

  typedef struct packed {
    logic [WORD_W-1:0] code;
    logic              last_word;
  } spoken_word_t;

  // typed_words == 0: no typed spelling, the predictor supplies it.
  typedef struct packed {
    logic [63:0]                  value;
    logic [2:0]                   typed_words;
    logic [0:3][WORD_W-1:0]       words;
  } directed_row_t;

  localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
    // zero spells as a single "none" word
    '{64'd0,                    3'd1, {CODE_NONE, W_PAD, W_PAD, W_PAD}},
    '{64'd1,                    3'd1, {W_ONE, W_PAD, W_PAD, W_PAD}},
    '{64'd10,                   3'd1, {CODE_TEN, W_PAD, W_PAD, W_PAD}},
    '{64'd19,                   3'd1, {W_NINETEEN, W_PAD, W_PAD, W_PAD}},
    '{64'd20,                   3'd1, {W_TWENTY, W_PAD, W_PAD, W_PAD}},
    '{64'd100,                  3'd2, {W_ONE, CODE_HUNDRED, W_PAD, W_PAD}},
    // exact powers of a thousand: no stray scale from the empty lower groups
    '{64'd1000,                 3'd2, {W_ONE, W_THOUSAND, W_PAD, W_PAD}},
    '{64'd1001,                 3'd3, {W_ONE, W_THOUSAND, W_ONE, W_PAD}},
    '{64'd1000000,              3'd2, {W_ONE, W_MILLION, W_PAD, W_PAD}},
    '{64'd1000000000,           3'd2, {W_ONE, W_BILLION, W_PAD, W_PAD}},
    '{64'd1000000000000,        3'd2, {W_ONE, W_TRILLION, W_PAD, W_PAD}},
    '{64'd1000000000000000,     3'd2, {W_ONE, W_QUADRILLION, W_PAD, W_PAD}},
    '{64'd1000000000000000000,  3'd2, {W_ONE, W_QUINTILLION, W_PAD, W_PAD}},
    '{64'd999,                  3'd0, {4{W_PAD}}},
    '{64'd110,                  3'd0, {4{W_PAD}}},
    '{64'd115,                  3'd0, {4{W_PAD}}},
    '{64'd12,                   3'd0, {4{W_PAD}}},
    '{64'd90,                   3'd0, {4{W_PAD}}},
    '{64'd1000001000,           3'd0, {4{W_PAD}}},
    '{64'd101010101,            3'd0, {4{W_PAD}}},
    '{64'd1000000000000000001,  3'd0, {4{W_PAD}}},
    '{64'h8000_0000_0000_0000,  3'd0, {4{W_PAD}}},
    '{64'h5555_5555_5555_5555,  3'd0, {4{W_PAD}}},
    '{64'hAAAA_AAAA_AAAA_AAAA,  3'd0, {4{W_PAD}}},
    // largest input: all 64 bits set
    '{64'hFFFF_FFFF_FFFF_FFFF,  3'd0, {4{W_PAD}}}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [63:0]       in_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WORD_W-1:0] out_word_code;
  logic              out_last_word;

  spoken_word_t pending_words [$];   // words still owed by the block, oldest first
  spoken_word_t oldest_word;
  int           error_count = 0;
  bit           long_hold_req = 1'b0;
  bit           quiet = 1'b0;

  always #4 clk = ~clk;

  number_to_english_words u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word_code (out_word_code),
    .out_last_word (out_last_word)
  );

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= 100) begin
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // Spell one number, short scale, and queue its words. Groups of three digits go
  // out most significant first; an all-zero group says nothing, not even its scale.
  function automatic void spell_number(input logic [63:0] raw);
    logic [63:0]  rest;
    int unsigned  grp [GROUPS];
    int unsigned  h, t, u;
    spoken_word_t words [$];
    rest = raw & ({64{1'b1}} >> (64 - VALUE_BITS));
    if (rest == 64'd0) begin
      pending_words.push_back('{CODE_NONE, 1'b1});
      return;
    end
    for (int g = 0; g < GROUPS; g++) begin
      grp[g] = int'(rest % 64'd1000);
      rest   = rest / 64'd1000;
    end
    for (int g = GROUPS - 1; g >= 0; g--) begin
      h = grp[g] / 100;
      t = (grp[g] / 10) % 10;
      u = grp[g] % 10;
      if (grp[g] != 0) begin
        if (h != 0) begin
          words.push_back('{WORD_W'(h), 1'b0});
          words.push_back('{CODE_HUNDRED, 1'b0});
        end
        if (t == 1 && u != 0) begin
          words.push_back('{CODE_TEN + WORD_W'(u), 1'b0});
        end else begin
          if (t == 1) words.push_back('{CODE_TEN, 1'b0});
          else if (t != 0) words.push_back('{CODE_TENS_BASE + WORD_W'(t), 1'b0});
          if (u != 0) words.push_back('{WORD_W'(u), 1'b0});
        end
        if (g > 0) words.push_back('{CODE_SCALE_BASE + WORD_W'(g), 1'b0});
      end
    end
    words[words.size() - 1].last_word = 1'b1;
    foreach (words[i]) pending_words.push_back(words[i]);
  endfunction

  // Mostly numbers built group by group, so zero groups, teens, round tens and
  // bare hundreds show up often; the rest are small values and raw 64-bit noise.
  function automatic logic [63:0] make_number();
    logic [63:0] value;
    logic [63:0] scale;
    int unsigned grp;
    case ($urandom_range(0, 19))
      0, 1, 2: value = {$urandom, $urandom};
      3, 4:    value = 64'($urandom_range(0, 1999));
      default: begin
        value = '0;
        scale = 64'd1;
        for (int g = 0; g < GROUPS; g++) begin
          case ($urandom_range(0, 5))
            0, 1:    grp = 0;
            2:       grp = $urandom_range(0, 9) * 100 + $urandom_range(10, 19);
            3:       grp = $urandom_range(1, 9) * 100 + $urandom_range(0, 9) * 10;
            4:       grp = $urandom_range(0, 9) * 100 + $urandom_range(0, 9);
            default: grp = $urandom_range(1, 999);
          endcase
          // keep the top group small enough that the sum fits in 64 bits
          if (g == GROUPS - 1) grp = grp % 18;
          value = value + 64'(grp) * scale;
          scale = scale * 64'd1000;
        end
      end
    endcase
    return value;
  endfunction

  // Offer one request and return once it is taken. Drop valid for a random
  // burst first now and then, unless the run is in its quiet tail.
  task automatic offer_number(input logic [63:0] value);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (in_stall);
  endtask

  // Sender: reset, directed table, random part, then drain and verdict.
  initial begin
    logic [63:0] value;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int row = 0; row < NUM_DIRECTED; row++) begin
      offer_number(DIRECTED[row].value);
      if (DIRECTED[row].typed_words == 0) begin
        spell_number(DIRECTED[row].value);
      end else begin
        for (int i = 0; i < DIRECTED[row].typed_words; i++) begin
          pending_words.push_back('{DIRECTED[row].words[i],
                                    i == DIRECTED[row].typed_words - 1});
        end
      end
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == HOLD_AT_ITEM) long_hold_req = 1'b1;
      if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      value = make_number();
      offer_number(value);
      spell_number(value);
    end
    in_valid <= 1'b0;

    // Hold until every owed word is in, then let the block settle.
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request so the block
  // fills up and stalls its input, and no stalls at all in the quiet tail.
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Scoreboard: compare each accepted word with the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        report_mismatch("word with nothing pending", 64'(out_word_code), 64'd0);
      end else begin
        oldest_word = pending_words.pop_front();
        if (out_word_code !== oldest_word.code) begin
          report_mismatch("word_code", 64'(out_word_code), 64'(oldest_word.code));
        end
        if (out_last_word !== oldest_word.last_word) begin
          report_mismatch("last_word", 64'(out_last_word), 64'(oldest_word.last_word));
        end
      end
    end
  end

  // Safety net: a hung handshake ends the run here.
  initial begin
    #6_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
